[src/plas_pkg.sv]
// ----------------------------------------------------------------------------
// plas_pkg
// Shared types and constants of the polyline arc length sampler.
// ----------------------------------------------------------------------------
package plas_pkg;

  localparam int unsigned MaxPoints   = 64;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned PtAw        = $clog2(MaxPoints);
  localparam int unsigned SegAw       = $clog2(MaxSegments);

  localparam logic [1:0] CmdWrPoint = 2'd0;
  localparam logic [1:0] CmdWrSeg   = 2'd1;
  localparam logic [1:0] CmdSample  = 2'd2;

  localparam logic [1:0] CfgPointCount = 2'd0;
  localparam logic [1:0] CfgSegCount   = 2'd1;
  localparam logic [1:0] CfgTotalLen   = 2'd2;

  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  typedef enum logic [4:0] {
    OpNone, OpWrPoint, OpWrSeg, OpDist, OpSegRd, OpSegChk, OpFallback,
    OpDivInit, OpDivStep, OpRdA, OpRdB, OpCapB, OpPrep, OpMag, OpScale,
    OpMulLo, OpMulHi, OpMulFin, OpSquare, OpSqrtInit, OpSqrtStep,
    OpTdivInit, OpTdivStep, OpTdivFin, OpDone
  } op_e;

  typedef enum logic [4:0] {
    StIdle, StSegRd, StSegChk, StWalkEnd, StDivInit, StDivStep, StRdA, StRdB,
    StCapB, StPrep, StMag, StScale, StMulLo, StMulHi, StMulFin, StSquare,
    StSqrtInit, StSqrt, StTdivInit, StTdivStep, StTdivFin, StDone
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] cnt;
    logic [1:0] axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic walk_end;
    logic seg_hit;
  } dp_status_t;

  typedef struct packed {
    logic [PtAw-1:0] first;
    logic [PtAw-1:0] second;
    logic            on;
    logic [31:0]     len;
  } seg_t;

endpackage

[src/plas_ctrl.sv]
// ----------------------------------------------------------------------------
// plas_ctrl
// Sequencer of the sampler: walks the segments, steps the divider on a hit,
// then the interpolator, square root and tangent divider of the datapath.
// ----------------------------------------------------------------------------
module plas_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           cmd_i,
  input  plas_pkg::dp_status_t status_i,
  output plas_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);
  import plas_pkg::*;

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (start_i && cmd_i == CmdSample) begin
          state_d = status_i.total_zero ? StRdA : StSegRd;
        end
      end
      StSegRd:    state_d = status_i.walk_end ? StWalkEnd : StSegChk;
      StSegChk: begin
        if (status_i.seg_hit) begin
          state_d = StDivInit;
        end else begin
          cnt_d   = cnt_q + 7'd1;
          state_d = StSegRd;
        end
      end
      StWalkEnd:  state_d = StRdA;
      StDivInit: begin
        cnt_d   = '0;
        state_d = StDivStep;
      end
      StDivStep: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd29) state_d = StRdA;
      end
      StRdA:      state_d = StRdB;
      StRdB:      state_d = StCapB;
      StCapB:     state_d = StPrep;
      StPrep:     state_d = StMag;
      StMag:      state_d = StScale;
      StScale: begin
        axis_d  = '0;
        state_d = StMulLo;
      end
      StMulLo:    state_d = StMulHi;
      StMulHi:    state_d = StMulFin;
      StMulFin: begin
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = StSquare;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = StMulLo;
        end
      end
      StSquare: begin
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = StSqrtInit;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      StSqrtInit: begin
        cnt_d   = '0;
        state_d = StSqrt;
      end
      StSqrt: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd31) state_d = StTdivInit;
      end
      StTdivInit: begin
        cnt_d   = '0;
        state_d = StTdivStep;
      end
      StTdivStep: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd14) state_d = StTdivFin;
      end
      StTdivFin: begin
        if (axis_q == 2'd2) begin
          state_d = StDone;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = StTdivInit;
        end
      end
      StDone:     state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o.cnt  = cnt_q;
    cmd_o.axis = axis_q;
    case (state_q)
      StIdle: begin
        if (!start_i) begin
          cmd_o.op = OpNone;
        end else begin
          case (cmd_i)
            CmdWrPoint: cmd_o.op = OpWrPoint;
            CmdWrSeg:   cmd_o.op = OpWrSeg;
            CmdSample:  cmd_o.op = OpDist;
            default:    cmd_o.op = OpNone;
          endcase
        end
      end
      StSegRd:    cmd_o.op = OpSegRd;
      StSegChk:   cmd_o.op = OpSegChk;
      StWalkEnd:  cmd_o.op = OpFallback;
      StDivInit:  cmd_o.op = OpDivInit;
      StDivStep:  cmd_o.op = OpDivStep;
      StRdA:      cmd_o.op = OpRdA;
      StRdB:      cmd_o.op = OpRdB;
      StCapB:     cmd_o.op = OpCapB;
      StPrep:     cmd_o.op = OpPrep;
      StMag:      cmd_o.op = OpMag;
      StScale:    cmd_o.op = OpScale;
      StMulLo:    cmd_o.op = OpMulLo;
      StMulHi:    cmd_o.op = OpMulHi;
      StMulFin:   cmd_o.op = OpMulFin;
      StSquare:   cmd_o.op = OpSquare;
      StSqrtInit: cmd_o.op = OpSqrtInit;
      StSqrt:     cmd_o.op = OpSqrtStep;
      StTdivInit: cmd_o.op = OpTdivInit;
      StTdivStep: cmd_o.op = OpTdivStep;
      StTdivFin:  cmd_o.op = OpTdivFin;
      StDone:     cmd_o.op = OpDone;
      default:    cmd_o.op = OpNone;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

[src/plas_dp.sv]
// ----------------------------------------------------------------------------
// plas_dp
// Datapath of the sampler: configuration registers, point and segment
// memories, walk arithmetic, interpolation and tangent normalization.
// ----------------------------------------------------------------------------
module plas_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  plas_pkg::ctrl_cmd_t  cmd_i,
  output plas_pkg::dp_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic [5:0]           slot_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic signed [31:0]   point_z_i,
  input  logic [5:0]           start_point_i,
  input  logic [5:0]           end_point_i,
  input  logic                 seg_active_i,
  input  logic [31:0]          seg_length_i,
  input  logic [16:0]          mu_i,
  output logic signed [31:0]   sample_x_o,
  output logic signed [31:0]   sample_y_o,
  output logic signed [31:0]   sample_z_o,
  output logic signed [15:0]   tangent_x_o,
  output logic signed [15:0]   tangent_y_o,
  output logic signed [15:0]   tangent_z_o,
  output logic                 done_o
);
  import plas_pkg::*;

  // Configuration.
  logic [6:0]  point_count_q, seg_count_q;
  logic [31:0] total_q;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      seg_count_q   <= '0;
      total_q       <= '0;
      done_q        <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OpDone);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPointCount: point_count_q <= cfg_wdata_i[6:0];
          CfgSegCount:   seg_count_q   <= cfg_wdata_i[6:0];
          CfgTotalLen:   total_q       <= cfg_wdata_i;
          default:       ;
        endcase
      end
    end
  end

  logic [6:0] nseg;
  assign nseg = (seg_count_q > 7'(MaxSegments)) ? 7'(MaxSegments) : seg_count_q;

  // Memories.
  logic [95:0] pt_mem [MaxPoints];
  seg_t        seg_mem [MaxSegments];
  logic [95:0] pt_rd_q;
  seg_t        seg_rd_q;
  seg_t        seg_wr;

  logic [PtAw-1:0] sel_first_q, sel_second_q, last_first_q, last_second_q;
  logic [PtAw-1:0] pt_addr;

  assign seg_wr.first  = start_point_i[PtAw-1:0];
  assign seg_wr.second = end_point_i[PtAw-1:0];
  assign seg_wr.on     = seg_active_i;
  assign seg_wr.len    = seg_length_i;
  assign pt_addr       = (cmd_i.op == OpRdA) ? sel_first_q : sel_second_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpWrPoint) begin
      pt_mem[slot_i[PtAw-1:0]] <= {point_z_i, point_y_i, point_x_i};
    end
    pt_rd_q <= pt_mem[pt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpWrSeg) begin
      seg_mem[slot_i[SegAw-1:0]] <= seg_wr;
    end
    seg_rd_q <= seg_mem[cmd_i.cnt[SegAw-1:0]];
  end

  // Walk.
  logic [31:0] dist_q, sel_len_q, rem_q;
  logic        last_valid_q;
  logic        dir_null_q;
  logic [30:0] t_q;
  logic [16:0] mu_sat;
  logic [48:0] dist_prod;
  logic [32:0] div_r2;

  assign mu_sat    = (mu_i > 17'd65536) ? 17'd65536 : mu_i;
  assign dist_prod = 49'(mu_sat) * 49'(total_q);
  assign div_r2    = {rem_q, 1'b0};

  assign status_o.total_zero = (total_q == '0);
  assign status_o.walk_end   = (cmd_i.cnt >= nseg);
  assign status_o.seg_hit    = seg_rd_q.on && (dist_q <= seg_rd_q.len);

  // Point operands and interpolation.
  logic [2:0][31:0]        pa_q, pb_q;
  logic signed [32:0]      diff_q [3];
  logic [32:0]             magraw_q [3];
  logic [2:0]              neg_q;
  logic [29:0]             mag_q [3];
  logic                    zero_dir_q;
  logic signed [65:0]      acc_q;
  logic [2:0][31:0]        pos_q;
  logic signed [16:0]      mul_op;
  logic signed [49:0]      prod;
  logic signed [65:0]      rnd;
  logic [32:0]             mag_or;
  logic [1:0]              shamt;

  assign mul_op = (cmd_i.op == OpMulHi) ? $signed({2'b00, t_q[30:16]})
                                        : $signed({1'b0, t_q[15:0]});
  assign prod   = diff_q[cmd_i.axis] * mul_op;
  assign rnd    = acc_q + 66'sd536870912;
  assign mag_or = magraw_q[0] | magraw_q[1] | magraw_q[2];

  always_comb begin
    if (mag_or[32])      shamt = 2'd3;
    else if (mag_or[31]) shamt = 2'd2;
    else if (mag_or[30]) shamt = 2'd1;
    else                 shamt = 2'd0;
  end

  // Norm and tangent division.
  logic [61:0] sum_q;
  logic [62:0] sq_v_q, sq_r_q, sq_bit_q, sq_trial;
  logic [59:0] sq;
  logic [31:0] norm;
  logic [46:0] tnum;
  logic [32:0] tdiv_d, trem_q;
  logic [14:0] tlo_q, tq_q;
  logic [33:0] tr2;
  logic [2:0][15:0] tan_q;

  assign sq       = 60'(mag_q[cmd_i.axis]) * 60'(mag_q[cmd_i.axis]);
  assign sq_trial = sq_r_q + sq_bit_q;
  assign norm     = sq_r_q[31:0];
  assign tnum     = (47'(mag_q[cmd_i.axis]) << 15) + 47'(norm);
  assign tdiv_d   = {norm, 1'b0};
  assign tr2      = {trem_q, tlo_q[14]};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpDist: begin
        dist_q       <= dist_prod[47:16];
        last_valid_q <= 1'b0;
        // With a zero total length the tangent stays along x.
        dir_null_q   <= (total_q == '0);
        sel_first_q  <= '0;
        sel_second_q <= '0;
        t_q          <= '0;
      end
      OpSegChk: begin
        if (seg_rd_q.on) begin
          last_first_q  <= seg_rd_q.first;
          last_second_q <= seg_rd_q.second;
          last_valid_q  <= 1'b1;
          if (dist_q <= seg_rd_q.len) begin
            sel_first_q  <= seg_rd_q.first;
            sel_second_q <= seg_rd_q.second;
            sel_len_q    <= seg_rd_q.len;
          end else begin
            dist_q <= dist_q - seg_rd_q.len;
          end
        end
      end
      OpFallback: begin
        // Past the end the last segment is taken at t equal to one.
        if (last_valid_q) begin
          sel_first_q  <= last_first_q;
          sel_second_q <= last_second_q;
          t_q          <= 31'h4000_0000;
        end else begin
          dir_null_q   <= 1'b1;
        end
      end
      OpDivInit: begin
        if (sel_len_q != '0 && dist_q == sel_len_q) begin
          t_q   <= 31'd1;
          rem_q <= '0;
        end else begin
          t_q   <= '0;
          rem_q <= dist_q;
        end
      end
      OpDivStep: begin
        if (sel_len_q != '0 && div_r2 >= {1'b0, sel_len_q}) begin
          rem_q <= 32'(div_r2 - {1'b0, sel_len_q});
          t_q   <= {t_q[29:0], 1'b1};
        end else begin
          rem_q <= div_r2[31:0];
          t_q   <= {t_q[29:0], 1'b0};
        end
      end
      OpRdB:  pa_q <= pt_rd_q;
      OpCapB: pb_q <= pt_rd_q;
      OpPrep: begin
        for (int k = 0; k < 3; k++) begin
          diff_q[k] <= $signed({pb_q[k][31], pb_q[k]}) - $signed({pa_q[k][31], pa_q[k]});
        end
      end
      OpMag: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k]    <= diff_q[k][32];
          magraw_q[k] <= diff_q[k][32] ? 33'(-diff_q[k]) : 33'(diff_q[k]);
        end
      end
      OpScale: begin
        for (int k = 0; k < 3; k++) begin
          mag_q[k] <= 30'(magraw_q[k] >> shamt);
        end
        zero_dir_q <= dir_null_q || (mag_or == '0);
        sum_q      <= '0;
      end
      OpMulLo: acc_q <= 66'(prod);
      OpMulHi: acc_q <= acc_q + (66'(prod) <<< 16);
      OpMulFin: begin
        if (point_count_q == '0) begin
          pos_q[cmd_i.axis] <= '0;
        end else begin
          pos_q[cmd_i.axis] <= pa_q[cmd_i.axis] + 32'(rnd >>> 30);
        end
      end
      OpSquare: sum_q <= sum_q + 62'(sq);
      OpSqrtInit: begin
        sq_v_q   <= 63'(sum_q);
        sq_r_q   <= '0;
        sq_bit_q <= 63'h4000_0000_0000_0000;
      end
      OpSqrtStep: begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q <= sq_v_q - sq_trial;
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OpTdivInit: begin
        trem_q <= {1'b0, tnum[46:15]};
        tlo_q  <= tnum[14:0];
        tq_q   <= '0;
      end
      OpTdivStep: begin
        tlo_q <= {tlo_q[13:0], 1'b0};
        if (tr2 >= {1'b0, tdiv_d}) begin
          trem_q <= 33'(tr2 - {1'b0, tdiv_d});
          tq_q   <= {tq_q[13:0], 1'b1};
        end else begin
          trem_q <= tr2[32:0];
          tq_q   <= {tq_q[13:0], 1'b0};
        end
      end
      OpTdivFin: begin
        if (zero_dir_q) begin
          tan_q[cmd_i.axis] <= (cmd_i.axis == 2'd0) ? OneQ14 : 16'sd0;
        end else if (neg_q[cmd_i.axis]) begin
          tan_q[cmd_i.axis] <= -16'({1'b0, tq_q});
        end else begin
          tan_q[cmd_i.axis] <= 16'({1'b0, tq_q});
        end
      end
      default: ;
    endcase
  end

  assign sample_x_o  = $signed(pos_q[0]);
  assign sample_y_o  = $signed(pos_q[1]);
  assign sample_z_o  = $signed(pos_q[2]);
  assign tangent_x_o = $signed(tan_q[0]);
  assign tangent_y_o = $signed(tan_q[1]);
  assign tangent_z_o = $signed(tan_q[2]);
  assign done_o      = done_q;

endmodule

[src/polyline_arc_length_sampler_core.sv]
// ----------------------------------------------------------------------------
// polyline_arc_length_sampler_core
// Samples a stored polyline at a fraction of its total rest length.
// ----------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low. Point and
// segment writes are done at the accepting edge and return nothing. A sample
// walks the segments, reading and then checking each in turn, and on a hit
// runs a 30-step divider for the segment parameter; with a zero total length
// the walk is skipped. Then come a 3-axis interpolation, a 32-step square root
// and a divide per tangent axis. The result word shows for one cycle with
// done_o and cannot be held off, so the receiver must take it then.
// Configuration is to be written by the user only while busy_o is low; the
// block does not enforce this.
module polyline_arc_length_sampler_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic [5:0]         slot_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [5:0]         start_point_i,
  input  logic [5:0]         end_point_i,
  input  logic               seg_active_i,
  input  logic [31:0]        seg_length_i,
  input  logic [16:0]        mu_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] sample_x_o,
  output logic signed [31:0] sample_y_o,
  output logic signed [31:0] sample_z_o,
  output logic signed [15:0] tangent_x_o,
  output logic signed [15:0] tangent_y_o,
  output logic signed [15:0] tangent_z_o
);
  import plas_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  plas_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  plas_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .slot_i        (slot_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .start_point_i (start_point_i),
    .end_point_i   (end_point_i),
    .seg_active_i  (seg_active_i),
    .seg_length_i  (seg_length_i),
    .mu_i          (mu_i),
    .sample_x_o    (sample_x_o),
    .sample_y_o    (sample_y_o),
    .sample_z_o    (sample_z_o),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .done_o        (done_o)
  );

endmodule
